>>> sv/bpc_pkg.sv
// Shared types, constants and arithmetic helpers for the pressure compensation block.
`default_nettype none
package bpc_pkg;

   typedef logic [31:0] word_type;

   localparam int DivSteps = 32;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW = 48;

   localparam logic [CsrIndexW-1:0] CsrCoefASigned = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrCoefAUnsigned = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrCoefBPair = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrCoefMPair = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrOversampling = 3'd4;

   localparam word_type TempOffset = 32'd4000;
   localparam word_type PressC3038 = 32'd3038;
   localparam word_type PressCNeg7357 = 32'hFFFF_E343;
   localparam word_type PressC3791 = 32'd3791;
   localparam word_type PressC50000 = 32'd50000;
   localparam word_type PressC32768 = 32'd32768;
   localparam word_type SignBit = 32'h8000_0000;

   typedef struct packed {
      logic signed [15:0] temp;
      logic fault;
      logic [18:0] up;
   } tag_type;

   typedef struct packed {
      word_type x1;
      logic qneg;
      tag_type tag;
   } side1_type;

   typedef struct packed {
      logic dbl;
      tag_type tag;
   } side2_type;

   function automatic word_type asr(input word_type v, input int n);
      return word_type'($signed(v) >>> n);
   endfunction

   function automatic word_type sdiv4(input word_type v);
      word_type bias;
      bias = v[31] ? 32'd3 : 32'd0;
      return asr(v + bias, 2);
   endfunction

   function automatic word_type sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic word_type mag(input word_type v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [95:0] div_step(input word_type rem, input word_type dq,
                                            input word_type dv);
      logic [32:0] trial;
      logic [32:0] diff;
      word_type r;
      logic qb;
      trial = {rem, dq[31]};
      diff = trial - {1'b0, dv};
      if (!diff[32]) begin
         r = diff[31:0];
         qb = 1'b1;
      end else begin
         r = trial[31:0];
         qb = 1'b0;
      end
      return {r, dq[30:0], qb, dv};
   endfunction

endpackage
`default_nettype wire

>>> sv/bpc_ifs.sv
// Handshake channel interfaces for request, response and register writes.
`default_nettype none
interface bpc_req_if;
   logic valid;
   logic ready;
   logic [15:0] raw_temperature;
   logic [18:0] raw_pressure;
   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] temperature_tenths;
   logic signed [20:0] pressure_pa;
   logic divide_fault;
   modport source (output valid, temperature_tenths, pressure_pa, divide_fault, input ready);
   modport sink (input valid, temperature_tenths, pressure_pa, divide_fault, output ready);
endinterface

interface bpc_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/bpc_udiv.sv
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
`default_nettype none
module bpc_udiv (
   input wire logic clock,
   input wire logic reset,
   input wire logic advance,
   input wire logic in_valid,
   input wire bpc_pkg::word_type dividend,
   input wire bpc_pkg::word_type divisor,
   output logic out_valid,
   output bpc_pkg::word_type quotient
);
   import bpc_pkg::*;

   logic vld_ff [DivSteps];
   word_type rem_ff [DivSteps];
   word_type dq_ff [DivSteps];
   word_type dv_ff [DivSteps];

   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic [95:0] step_in;
      if (i == 0) begin : g_first
         assign step_in = div_step(32'd0, dividend, divisor);
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (advance) begin
               vld_ff[i] <= in_valid;
            end
         end
      end else begin : g_rest
         assign step_in = div_step(rem_ff[i-1], dq_ff[i-1], dv_ff[i-1]);
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (advance) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= step_in[95:64];
            dq_ff[i] <= step_in[63:32];
            dv_ff[i] <= step_in[31:0];
         end
      end
   end

   assign out_valid = vld_ff[DivSteps-1];
   assign quotient = dq_ff[DivSteps-1];
endmodule
`default_nettype wire

>>> sv/barometric_pressure_compensation.sv
// Top level: temperature and pressure compensation pipeline.
// Channel | Direction | Content
// req     | in        | raw_temperature, raw_pressure
// rsp     | out       | temperature_tenths, pressure_pa, divide_fault
// csr     | in        | index, data (register write)
// One request per cycle unless the response stalls; two 32-stage dividers.
// Reset clears all valid bits and the registers; payload stages are not reset.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
// csr writes are always taken.
`default_nettype none
module barometric_pressure_compensation (
   input wire logic clock,
   input wire logic reset,
   bpc_req_if.sink req_chan,
   bpc_rsp_if.source rsp_chan,
   bpc_csr_if.sink csr_chan
);
   import bpc_pkg::*;

   logic [47:0] coef_as_ff, coef_au_ff;
   logic [31:0] coef_b_ff, coef_m_ff;
   logic [1:0] oss_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_as_ff <= '0;
         coef_au_ff <= '0;
         coef_b_ff <= '0;
         coef_m_ff <= '0;
         oss_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CsrCoefASigned: coef_as_ff <= csr_chan.data;
            CsrCoefAUnsigned: coef_au_ff <= csr_chan.data;
            CsrCoefBPair: coef_b_ff <= csr_chan.data[31:0];
            CsrCoefMPair: coef_m_ff <= csr_chan.data[31:0];
            CsrOversampling: oss_ff <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   word_type ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(coef_as_ff[15:0]);
   assign ac2 = sx16(coef_as_ff[31:16]);
   assign ac3 = sx16(coef_as_ff[47:32]);
   assign ac4 = {16'd0, coef_au_ff[15:0]};
   assign ac5 = {16'd0, coef_au_ff[31:16]};
   assign ac6 = {16'd0, coef_au_ff[47:32]};
   assign b1 = sx16(coef_b_ff[15:0]);
   assign b2 = sx16(coef_b_ff[31:16]);
   assign mc = sx16(coef_m_ff[15:0]);
   assign md = sx16(coef_m_ff[31:16]);

   logic adv;
   logic out_vld_ff;
   assign adv = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // front: raw temperature to first divider
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   word_type s1_ut_ff, s2_t1_ff;
   tag_type s1_tag_ff, s2_tag_ff;
   word_type s3_num_ff, s3_den_ff;
   side1_type s3_side_ff;
   word_type x1_a, den_a;
   tag_type tag_in;

   always_comb begin
      tag_in.temp = '0;
      tag_in.fault = 1'b0;
      tag_in.up = req_chan.raw_pressure;
   end

   assign x1_a = asr(s2_t1_ff, 15);
   assign den_a = x1_a + md;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_chan.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ut_ff <= {16'd0, req_chan.raw_temperature};
         s1_tag_ff <= tag_in;
         s2_t1_ff <= (s1_ut_ff - ac6) * ac5;
         s2_tag_ff <= s1_tag_ff;
         s3_num_ff <= mag(mc << 11);
         s3_den_ff <= mag(den_a);
         s3_side_ff.x1 <= x1_a;
         s3_side_ff.qneg <= mc[31] ^ den_a[31];
         s3_side_ff.tag.temp <= s2_tag_ff.temp;
         s3_side_ff.tag.up <= s2_tag_ff.up;
         s3_side_ff.tag.fault <= (den_a == 32'd0);
      end
   end

   logic d1_vld;
   word_type d1_q;
   side1_type side1_ff [DivSteps];

   bpc_udiv u_div_temp (
      .clock(clock), .reset(reset), .advance(adv), .in_valid(s3_vld_ff),
      .dividend(s3_num_ff), .divisor(s3_den_ff), .out_valid(d1_vld), .quotient(d1_q)
   );

   for (genvar i = 0; i < DivSteps; i++) begin : g_side1
      always_ff @(posedge clock) begin
         if (adv) begin
            side1_ff[i] <= (i == 0) ? s3_side_ff : side1_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // middle: b5 through the b4/b7 terms
   side1_type d1_side;
   assign d1_side = side1_ff[DivSteps-1];

   logic s4_vld_ff, s5_vld_ff, s6_vld_ff, s7_vld_ff, s8_vld_ff, s9_vld_ff;
   logic s10_vld_ff, s11_vld_ff, s12_vld_ff;
   word_type s4_b5_ff;
   tag_type s4_tag_ff, s5_tag_ff, s6_tag_ff, s7_tag_ff, s8_tag_ff, s9_tag_ff;
   tag_type s10_tag_ff, s11_tag_ff;
   word_type s5_b6_ff;
   word_type s6_sqm_ff, s6_m2_ff, s6_m3_ff;
   word_type s7_sq_ff, s7_x2a_ff, s7_x1c_ff;
   word_type s8_p1_ff, s8_p2_ff, s8_x2a_ff, s8_x1c_ff;
   word_type s9_b3_ff, s9_x3b_ff;
   word_type s10_b4m_ff, s10_diff_ff;
   word_type s11_b4m_ff, s11_b7_ff;
   word_type s12_num_ff, s12_den_ff;
   side2_type s12_side_ff;

   word_type x2_d, b5_d, t_wide, x3_h, b3pre_h, x3b_h, b4_k;
   logic signed [31:0] t_s;
   logic signed [15:0] t_sat;

   assign x2_d = d1_side.qneg ? (32'd0 - d1_q) : d1_q;
   assign b5_d = d1_side.x1 + x2_d;
   assign t_wide = asr(s4_b5_ff + 32'd8, 4);
   assign t_s = $signed(t_wide);
   always_comb begin
      if (t_s > 32'sd32767) begin
         t_sat = 16'sd32767;
      end else if (t_s < -32'sd32768) begin
         t_sat = -16'sd32768;
      end else begin
         t_sat = t_s[15:0];
      end
   end

   assign x3_h = asr(s8_p1_ff, 11) + s8_x2a_ff;
   assign b3pre_h = (((ac1 << 2) + x3_h) << oss_ff) + 32'd2;
   assign x3b_h = s8_x1c_ff + asr(s8_p2_ff, 16) + 32'd2;
   assign b4_k = s11_b4m_ff >> 15;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         s9_vld_ff <= 1'b0;
         s10_vld_ff <= 1'b0;
         s11_vld_ff <= 1'b0;
         s12_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= d1_vld;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
         s9_vld_ff <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         s11_vld_ff <= s10_vld_ff;
         s12_vld_ff <= s11_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_b5_ff <= b5_d;
         s4_tag_ff <= d1_side.tag;
         s5_b6_ff <= s4_b5_ff - TempOffset;
         s5_tag_ff.temp <= t_sat;
         s5_tag_ff.fault <= s4_tag_ff.fault;
         s5_tag_ff.up <= s4_tag_ff.up;
         s6_sqm_ff <= s5_b6_ff * s5_b6_ff;
         s6_m2_ff <= ac2 * s5_b6_ff;
         s6_m3_ff <= ac3 * s5_b6_ff;
         s6_tag_ff <= s5_tag_ff;
         s7_sq_ff <= asr(s6_sqm_ff, 12);
         s7_x2a_ff <= asr(s6_m2_ff, 11);
         s7_x1c_ff <= asr(s6_m3_ff, 13);
         s7_tag_ff <= s6_tag_ff;
         s8_p1_ff <= b2 * s7_sq_ff;
         s8_p2_ff <= b1 * s7_sq_ff;
         s8_x2a_ff <= s7_x2a_ff;
         s8_x1c_ff <= s7_x1c_ff;
         s8_tag_ff <= s7_tag_ff;
         s9_b3_ff <= sdiv4(b3pre_h);
         s9_x3b_ff <= sdiv4(x3b_h);
         s9_tag_ff <= s8_tag_ff;
         s10_b4m_ff <= ac4 * (s9_x3b_ff + PressC32768);
         s10_diff_ff <= {13'd0, s9_tag_ff.up} - s9_b3_ff;
         s10_tag_ff <= s9_tag_ff;
         s11_b4m_ff <= s10_b4m_ff;
         s11_b7_ff <= s10_diff_ff * (PressC50000 >> oss_ff);
         s11_tag_ff <= s10_tag_ff;
         s12_den_ff <= b4_k;
         s12_num_ff <= (s11_b7_ff < SignBit) ? (s11_b7_ff << 1) : s11_b7_ff;
         s12_side_ff.dbl <= !(s11_b7_ff < SignBit);
         s12_side_ff.tag.temp <= s11_tag_ff.temp;
         s12_side_ff.tag.up <= s11_tag_ff.up;
         s12_side_ff.tag.fault <= s11_tag_ff.fault || (b4_k == 32'd0);
      end
   end

   logic d2_vld;
   word_type d2_q;
   side2_type side2_ff [DivSteps];

   bpc_udiv u_div_press (
      .clock(clock), .reset(reset), .advance(adv), .in_valid(s12_vld_ff),
      .dividend(s12_num_ff), .divisor(s12_den_ff), .out_valid(d2_vld), .quotient(d2_q)
   );

   for (genvar i = 0; i < DivSteps; i++) begin : g_side2
      always_ff @(posedge clock) begin
         if (adv) begin
            side2_ff[i] <= (i == 0) ? s12_side_ff : side2_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // back: pressure correction and output register
   side2_type d2_side;
   assign d2_side = side2_ff[DivSteps-1];

   logic s13_vld_ff, s14_vld_ff, s15_vld_ff;
   word_type s13_p_ff, s14_p_ff, s15_p_ff;
   word_type s14_sq_ff, s14_m7_ff, s15_x1m_ff, s15_x2_ff;
   tag_type s13_tag_ff, s14_tag_ff, s15_tag_ff;
   word_type s_p, pf;
   logic signed [31:0] pf_s;
   logic signed [20:0] p_sat;

   assign s_p = asr(s13_p_ff, 8);
   assign pf = s15_p_ff + asr(asr(s15_x1m_ff, 16) + s15_x2_ff + PressC3791, 4);
   assign pf_s = $signed(pf);
   always_comb begin
      if (pf_s > 32'sd1048575) begin
         p_sat = 21'sd1048575;
      end else if (pf_s < -32'sd1048576) begin
         p_sat = -21'sd1048576;
      end else begin
         p_sat = pf_s[20:0];
      end
   end

   logic signed [15:0] out_t_ff;
   logic signed [20:0] out_p_ff;
   logic out_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_vld_ff <= 1'b0;
         s14_vld_ff <= 1'b0;
         s15_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s13_vld_ff <= d2_vld;
         s14_vld_ff <= s13_vld_ff;
         s15_vld_ff <= s14_vld_ff;
         out_vld_ff <= s15_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s13_p_ff <= d2_side.dbl ? (d2_q << 1) : d2_q;
         s13_tag_ff <= d2_side.tag;
         s14_sq_ff <= s_p * s_p;
         s14_m7_ff <= PressCNeg7357 * s13_p_ff;
         s14_p_ff <= s13_p_ff;
         s14_tag_ff <= s13_tag_ff;
         s15_x1m_ff <= s14_sq_ff * PressC3038;
         s15_x2_ff <= asr(s14_m7_ff, 16);
         s15_p_ff <= s14_p_ff;
         s15_tag_ff <= s14_tag_ff;
         out_t_ff <= s15_tag_ff.fault ? 16'sd0 : s15_tag_ff.temp;
         out_p_ff <= s15_tag_ff.fault ? 21'sd0 : p_sat;
         out_f_ff <= s15_tag_ff.fault;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.temperature_tenths = out_t_ff;
   assign rsp_chan.pressure_pa = out_p_ff;
   assign rsp_chan.divide_fault = out_f_ff;
endmodule
`default_nettype wire
